@@ sv/shq_pkg.sv @@
// shared types and constants of the spline histogram quantile block
package shq_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MAX_BINS   = 1024;
	localparam int MAX_QUANTS = 64;
	localparam int BIN_AW     = $clog2(MAX_BINS);
	localparam int BIN_W      = 40;
	localparam int CUM_W      = 51;
	localparam int TGT_W      = 55;
	localparam int PROD_W     = 58;
	localparam int DEN_W      = 48;
	localparam int NUMER_W    = 27;
	localparam int STEP_W     = 5;

	localparam logic [16:0]      ONE      = 17'h10000;
	localparam logic [BIN_W-1:0] BIN_MAX  = {BIN_W{1'b1}};
	localparam logic [CUM_W-1:0] CUM_MAX  = {1'b1, {(CUM_W-1){1'b0}}};

	localparam logic [0:0] REG_BIN_COUNT   = 1'b0;
	localparam logic [0:0] REG_QUANT_COUNT = 1'b1;

	typedef struct packed {
		logic signed [17:0] sample;
		logic               last_sample;
	} item_t;

	typedef struct packed {
		logic [5:0]  quantile_index;
		logic [16:0] quantile_level;
		logic        too_few_samples;
		logic        last_result;
	} result_t;

	typedef struct packed {
		logic               start;
		logic [DEN_W-1:0]   rem0;
		logic [DEN_W-1:0]   den;
		logic [NUMER_W-1:0] numer;
		logic [STEP_W-1:0]  steps;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [NUMER_W-1:0] quot;
	} div_rsp_t;

endpackage

@@ sv/shq_bin_mem.sv @@
// histogram bin memory, one write and one registered read port
module shq_bin_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [shq_pkg::BIN_AW-1:0] waddr,
	input  logic [shq_pkg::BIN_W-1:0]  wdata,
	input  logic [shq_pkg::BIN_AW-1:0] raddr,
	output logic [shq_pkg::BIN_W-1:0]  rdata
);
	import shq_pkg::*;

	logic [BIN_W-1:0] mem [MAX_BINS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/shq_div.sv @@
// serial restoring divider, one quotient bit per cycle
module shq_div (
	input  logic              clk,
	input  logic              arst_n,
	input  shq_pkg::div_req_t req,
	output shq_pkg::div_rsp_t rsp
);
	import shq_pkg::*;

	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic [NUMER_W-1:0] numer_q;
	logic [NUMER_W-1:0] quot_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DEN_W-1:0]   rem_sh;
	logic               qbit;

	assign rem_sh = {rem_q[DEN_W-2:0], numer_q[NUMER_W-1]};
	assign qbit   = rem_sh >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q   <= req.rem0;
			den_q   <= req.den;
			numer_q <= req.numer;
			quot_q  <= '0;
		end else if (busy_q) begin
			rem_q   <= qbit ? rem_sh - den_q : rem_sh;
			numer_q <= {numer_q[NUMER_W-2:0], 1'b0};
			quot_q  <= {quot_q[NUMER_W-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

@@ sv/spline_histogram_quantiles.sv @@
// top level: spline kernel histogram with quantile readout
// Usage:
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 is bin_count,
//   1 is quantile_count; cfg_ready is always high, write only while idle.
//   Input: a sample beat is taken when start is high and busy is low.
//   Each ordinary sample keeps busy high after it is taken, and no new sample
//   is taken until it is through: position multiply, weight multiply, then
//   three read-modify-write passes on the bin memory.
//   A beat with last_sample set runs the readout afterward: read, data,
//   multiply and test steps per bin walked plus, per quantile, a 16-step fraction
//   divide when needed and a 27-step level divide in the shared serial divider.
//   Results: result_valid is high for exactly one cycle per result beat; the
//   receiver cannot stall, so results are never held.
//   After each run and after reset all 1024 bin memory entries are cleared,
//   one entry per cycle, while busy stays high; configuration writes are
//   still taken.
module spline_histogram_quantiles (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             start,
	output logic             busy,
	input  shq_pkg::item_t   item,
	output logic             result_valid,
	output shq_pkg::result_t result
);
	import shq_pkg::*;

	typedef enum logic [14:0] {
		S_CLEAR = 15'h0001,
		S_IDLE  = 15'h0002,
		S_MUL   = 15'h0004,
		S_WGT   = 15'h0008,
		S_RD    = 15'h0010,
		S_WR    = 15'h0020,
		S_CHK   = 15'h0040,
		S_ERR   = 15'h0080,
		S_BRD   = 15'h0100,
		S_BDAT  = 15'h0200,
		S_BMUL  = 15'h0400,
		S_TEST  = 15'h0800,
		S_FDIV  = 15'h1000,
		S_LDIV  = 15'h2000,
		S_FILL  = 15'h4000
	} state_t;

	state_t state_q;

	logic [10:0] bin_count_q;
	logic [6:0]  quant_count_q;
	logic [10:0] nb;
	logic [6:0]  nq;
	logic [7:0]  q1;

	logic [16:0]       mag_q;
	logic              last_q;
	logic [27:0]       p_q;
	logic [10:0]       c_q;
	logic [31:0]       ff_q;
	logic [33:0]       gg_q;
	logic [1:0]        j_q;
	logic [31:0]       total_q;
	logic [BIN_AW:0]   clr_q;

	logic [10:0]       i_q;
	logic [6:0]        k_q;
	logic [CUM_W-1:0]  cum_q;
	logic [CUM_W-1:0]  nxt_q;
	logic [BIN_W-1:0]  d_q;
	logic [TGT_W-1:0]  target_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] cumq_q;
	logic [DEN_W-1:0]  den_q;
	logic [16:0]       lvl_q;

	logic              res_valid_q;
	result_t           res_q;

	logic [17:0]       raw_abs;
	logic [16:0]       mag;
	logic [15:0]       f;
	logic [16:0]       g;
	logic [16:0]       w0, w1, w2, w;
	logic signed [12:0] idx_raw;
	logic [BIN_AW-1:0] idx;
	logic [BIN_W:0]    sum;
	logic [CUM_W:0]    nxt_sum;
	logic [PROD_W-1:0] num;
	logic              hit;
	logic [16:0]       t_sel;

	logic              mem_we;
	logic [BIN_AW-1:0] mem_waddr;
	logic [BIN_W-1:0]  mem_wdata;
	logic [BIN_AW-1:0] mem_raddr;
	logic [BIN_W-1:0]  mem_rdata;

	div_req_t          div_req;
	div_rsp_t          div_rsp;

	shq_bin_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	shq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// effective register values
	always_comb begin
		if (bin_count_q == '0) begin
			nb = 11'd1;
		end else if (bin_count_q > 11'(MAX_BINS)) begin
			nb = 11'(MAX_BINS);
		end else begin
			nb = bin_count_q;
		end
		if (quant_count_q == '0) begin
			nq = 7'd1;
		end else if (quant_count_q > 7'(MAX_QUANTS)) begin
			nq = 7'(MAX_QUANTS);
		end else begin
			nq = quant_count_q;
		end
		q1 = {1'b0, nq} + 8'd1;
	end

	// magnitude clamped to 1.0
	assign raw_abs = item.sample[17] ? 18'(-item.sample) : 18'(item.sample);
	assign mag     = (raw_abs > 18'(ONE)) ? ONE : raw_abs[16:0];

	assign f  = p_q[15:0];
	assign g  = ONE - {1'b0, f};
	assign w2 = 17'(ff_q >> (FRAC_BITS + 1));
	assign w0 = 17'(gg_q >> (FRAC_BITS + 1));
	assign w1 = ONE - w0 - w2;

	always_comb begin
		unique case (j_q)
			2'd0:    w = w0;
			2'd1:    w = w1;
			default: w = w2;
		endcase
		idx_raw = $signed({2'b00, c_q}) + $signed({11'd0, j_q}) - 13'sd1;
		if (idx_raw < 13'sd0) begin
			idx = '0;
		end else if (idx_raw > $signed({2'b00, nb}) - 13'sd1) begin
			idx = BIN_AW'(nb - 11'd1);
		end else begin
			idx = idx_raw[BIN_AW-1:0];
		end
	end

	assign sum     = {1'b0, mem_rdata} + (BIN_W+1)'(w);
	assign nxt_sum = {1'b0, cum_q} + (CUM_W+1)'(mem_rdata);
	assign num     = PROD_W'(target_q) - cumq_q;
	assign hit     = (k_q < nq) && (prod_q >= PROD_W'(target_q));

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx;
		mem_wdata = (sum > (BIN_W+1)'(BIN_MAX)) ? BIN_MAX : sum[BIN_W-1:0];
		mem_raddr = idx;
		priority case (1'b1)
			state_q == S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q[BIN_AW-1:0];
				mem_wdata = '0;
			end
			state_q == S_WR: begin
				mem_we = 1'b1;
			end
			state_q == S_BRD: begin
				mem_raddr = i_q[BIN_AW-1:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// divider requests
	always_comb begin
		div_req = '0;
		t_sel   = (den_q == '0) ? 17'd0 : ONE;
		if (state_q == S_FDIV) begin
			t_sel = div_rsp.quot[16:0];
		end
		if (state_q == S_TEST && hit && den_q != '0 && num < PROD_W'(den_q)) begin
			div_req.start = 1'b1;
			div_req.rem0  = num[DEN_W-1:0];
			div_req.den   = den_q;
			div_req.numer = '0;
			div_req.steps = STEP_W'(FRAC_BITS);
		end else if ((state_q == S_TEST && hit) || (state_q == S_FDIV && div_rsp.done)) begin
			div_req.start = 1'b1;
			div_req.rem0  = '0;
			div_req.den   = DEN_W'(nb);
			div_req.numer = {1'b0, i_q[BIN_AW-1:0], 16'd0} + NUMER_W'(t_sel);
			div_req.steps = STEP_W'(NUMER_W);
		end
	end

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q   <= 11'd256;
			quant_count_q <= 7'd8;
		end else if (cfg_valid && cfg_ready && cfg_index[7:1] == '0) begin
			unique case (cfg_index[0])
				REG_BIN_COUNT:   bin_count_q   <= cfg_data[10:0];
				REG_QUANT_COUNT: quant_count_q <= cfg_data[6:0];
				default:         bin_count_q   <= bin_count_q;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			j_q         <= '0;
			total_q     <= '0;
			i_q         <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					total_q <= '0;
					clr_q   <= clr_q + 1'b1;
					if (clr_q == (BIN_AW+1)'(MAX_BINS - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (total_q != '1) begin
						total_q <= total_q + 1'b1;
					end
					state_q <= S_WGT;
				end
				S_WGT: begin
					j_q     <= '0;
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					j_q <= j_q + 1'b1;
					if (j_q != 2'd2) begin
						state_q <= S_RD;
					end else if (last_q) begin
						state_q <= S_CHK;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_CHK: begin
					i_q <= '0;
					k_q <= '0;
					if (total_q <= 32'(nq)) begin
						state_q <= S_ERR;
					end else begin
						state_q <= S_BRD;
					end
				end
				S_ERR: begin
					res_valid_q <= 1'b1;
					state_q     <= S_CLEAR;
				end
				S_BRD: begin
					if (i_q == nb || k_q == nq) begin
						state_q <= S_FILL;
					end else begin
						state_q <= S_BDAT;
					end
				end
				S_BDAT: begin
					state_q <= S_BMUL;
				end
				S_BMUL: begin
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (!hit) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_BRD;
					end else if (div_req.steps == STEP_W'(FRAC_BITS)) begin
						state_q <= S_FDIV;
					end else begin
						state_q <= S_LDIV;
					end
				end
				S_FDIV: begin
					if (div_rsp.done) begin
						state_q <= S_LDIV;
					end
				end
				S_LDIV: begin
					if (div_rsp.done) begin
						res_valid_q <= 1'b1;
						k_q         <= k_q + 1'b1;
						state_q     <= S_TEST;
					end
				end
				S_FILL: begin
					if (k_q < nq) begin
						res_valid_q <= 1'b1;
						k_q         <= k_q + 1'b1;
					end else begin
						state_q <= S_CLEAR;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mag_q  <= mag;
			last_q <= item.last_sample;
		end
		if (state_q == S_MUL) begin
			p_q <= 28'(mag_q) * 28'(nb);
		end
		if (state_q == S_WGT) begin
			c_q  <= p_q[26:16];
			ff_q <= f * f;
			gg_q <= g * g;
		end
		if (state_q == S_CHK) begin
			cum_q    <= '0;
			lvl_q    <= '0;
			target_q <= TGT_W'({total_q, 16'd0});
		end
		if (state_q == S_BDAT) begin
			d_q   <= mem_rdata;
			nxt_q <= (nxt_sum > (CUM_W+1)'(CUM_MAX)) ? CUM_MAX : nxt_sum[CUM_W-1:0];
		end
		if (state_q == S_BMUL) begin
			prod_q <= PROD_W'(nxt_q) * PROD_W'(q1);
			cumq_q <= PROD_W'(cum_q) * PROD_W'(q1);
			den_q  <= DEN_W'(d_q) * DEN_W'(q1);
		end
		if (state_q == S_TEST && !hit) begin
			cum_q <= nxt_q;
		end
		res_q.too_few_samples <= 1'b0;
		res_q.quantile_index  <= k_q[5:0];
		res_q.last_result     <= (k_q + 7'd1) == nq;
		res_q.quantile_level  <= lvl_q;
		if (state_q == S_LDIV && div_rsp.done) begin
			lvl_q                <= div_rsp.quot[16:0];
			res_q.quantile_level <= div_rsp.quot[16:0];
			target_q             <= target_q + TGT_W'({total_q, 16'd0});
		end
		if (state_q == S_ERR) begin
			res_q.quantile_index  <= '0;
			res_q.quantile_level  <= '0;
			res_q.too_few_samples <= 1'b1;
			res_q.last_result     <= 1'b1;
		end
	end

	assign busy         = state_q != S_IDLE;
	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef NO_ASSERTIONS
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.too_few_samples |-> result.last_result)
		else $error("error result without last mark");
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result while idle");
	a_accept_mul: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_MUL)
		else $error("accepted sample not processed");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// testbench of spline_histogram_quantiles: directed table then random runs, checked by a predictor
module tb;
	import shq_pkg::*;

	typedef struct {
		logic signed [17:0] sample;
		bit                 last;
		bit                 typed;
		result_t            want;
	} dir_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic    start = 1'b0;
	logic    busy;
	item_t   item = '0;
	logic    result_valid;
	result_t result;

	longint unsigned hist_bins [MAX_BINS];
	longint unsigned sample_cnt;
	longint unsigned bins_reg;
	longint unsigned quants_reg;
	result_t         level_q [$];
	int              errors = 0;

	spline_histogram_quantiles dut (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .start(start), .busy(busy),
		.item(item), .result_valid(result_valid), .result(result)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic void hist_clear();
		foreach (hist_bins[i]) hist_bins[i] = 0;
		sample_cnt = 0;
	endfunction

	function automatic void hist_add(longint signed idx, longint unsigned nb, longint unsigned w);
		longint unsigned s;
		if (idx < 0) idx = 0;
		if (idx > longint'(nb) - 1) idx = nb - 1;
		s = hist_bins[idx] + w;
		hist_bins[idx] = (s > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : s;
	endfunction

	function automatic longint unsigned frac_of(longint unsigned num, longint unsigned den);
		longint unsigned t, r;
		t = 0;
		r = num;
		if (r >= den) return 64'h10000;
		for (int b = 0; b < FRAC_BITS; b++) begin
			r = r << 1;
			t = t << 1;
			if (r >= den) begin
				r -= den;
				t |= 1;
			end
		end
		return t;
	endfunction

	// accumulate one sample; on the final one, queue the quantile levels, or the too-few-samples error result
	function automatic void quantile_predict(logic signed [17:0] s, bit last);
		longint unsigned nb, q, q1, raw, mag, p, f, g, w0, w1, w2, n, cum, lvl, k, d, nxt;
		longint unsigned num, den, t;
		longint signed c;
		result_t r;
		nb = (bins_reg == 0) ? 1 : (bins_reg > MAX_BINS ? MAX_BINS : bins_reg);
		q = (quants_reg == 0) ? 1 : (quants_reg > MAX_QUANTS ? MAX_QUANTS : quants_reg);
		q1 = q + 1;
		raw = {46'b0, s};
		mag = raw[17] ? ((64'h40000 - raw) & 64'h3FFFF) : raw;
		if (raw == 64'h20000) mag = 64'h20000;
		if (mag > 64'h10000) mag = 64'h10000;
		p = mag * nb;
		c = longint'(p >> FRAC_BITS);
		f = p & 64'hFFFF;
		g = 64'h10000 - f;
		w2 = (f * f) >> (FRAC_BITS + 1);
		w0 = (g * g) >> (FRAC_BITS + 1);
		w1 = 64'h10000 - w0 - w2;
		hist_add(c - 1, nb, w0);
		hist_add(c, nb, w1);
		hist_add(c + 1, nb, w2);
		if (sample_cnt != 64'hFFFF_FFFF) sample_cnt++;
		if (!last) return;
		n = sample_cnt;
		if (n <= q) begin
			r = '{quantile_index: '0, quantile_level: '0, too_few_samples: 1'b1, last_result: 1'b1};
			level_q.push_back(r);
			hist_clear();
			return;
		end
		cum = 0;
		lvl = 0;
		k = 0;
		for (longint unsigned i = 0; i < nb && k < q; i++) begin
			d = hist_bins[i];
			nxt = cum + d;
			if (nxt > (64'd1 << 50)) nxt = 64'd1 << 50;
			while (k < q && nxt * q1 >= (k + 1) * n * 64'h10000) begin
				num = (k + 1) * n * 64'h10000 - cum * q1;
				den = q1 * d;
				t = (den == 0) ? 0 : frac_of(num, den);
				lvl = (64'h10000 * i + t) / nb;
				r.quantile_index = k[5:0];
				r.quantile_level = lvl[16:0];
				r.too_few_samples = 1'b0;
				r.last_result = (k + 1 == q);
				level_q.push_back(r);
				k++;
			end
			cum = nxt;
		end
		for (; k < q; k++) begin
			r.quantile_index = k[5:0];
			r.quantile_level = lvl[16:0];
			r.too_few_samples = 1'b0;
			r.last_result = (k + 1 == q);
			level_q.push_back(r);
		end
		hist_clear();
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid) begin
			if (level_q.size() == 0) begin
				$error("unexpected result beat %p", result);
				errors++;
			end else begin
				want = level_q.pop_front();
				if (result.quantile_index !== want.quantile_index) begin
					$error("quantile_index expected %0d actual %0d", want.quantile_index,
						result.quantile_index);
					errors++;
				end
				if (result.quantile_level !== want.quantile_level) begin
					$error("quantile_level expected %0d actual %0d", want.quantile_level,
						result.quantile_level);
					errors++;
				end
				if (result.too_few_samples !== want.too_few_samples) begin
					$error("too_few_samples expected %0b actual %0b", want.too_few_samples,
						result.too_few_samples);
					errors++;
				end
				if (result.last_result !== want.last_result) begin
					$error("last_result expected %0b actual %0b", want.last_result,
						result.last_result);
					errors++;
				end
			end
		end
	end

	task automatic cfg_write(logic [7:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == 8'(REG_BIN_COUNT)) bins_reg = val & 16'h7FF;
		else if (idx == 8'(REG_QUANT_COUNT)) quants_reg = val & 16'h7F;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one beat; typed rows replace the predicted results with the table's own
	task automatic send_sample(logic signed [17:0] s, bit last, bit typed = 0,
			result_t want = '0);
		int gap;
		int prior_len;
		start <= 1'b1;
		item <= '{sample: s, last_sample: last};
		do @(posedge clk); while (busy);
		prior_len = level_q.size();
		quantile_predict(s, last);
		if (typed) begin
			while (level_q.size() > prior_len) void'(level_q.pop_back());
			level_q.push_back(want);
		end
		@(negedge clk);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (level_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [17:0] rand_sample();
		case ($urandom_range(0, 3))
			0: return 18'($urandom);
			1: return 18'($urandom_range(0, 65536));
			2: return -$signed({1'b0, 17'($urandom_range(0, 65536))});
			default: return 18'($urandom_range(0, 2000));
		endcase
	endfunction

	initial begin
		dir_row_t rows [$];
		result_t  err_res;
		int       n, q;
		logic [15:0] bv, qv;
		hist_clear();
		bins_reg = 256;
		quants_reg = 8;
		err_res = '{quantile_index: '0, quantile_level: '0, too_few_samples: 1'b1, last_result: 1'b1};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		rows.push_back('{18'sd100, 1, 1, err_res});
		rows.push_back('{18'sd131071, 0, 0, '0});
		rows.push_back('{-18'sd131072, 0, 0, '0});
		rows.push_back('{18'sd65536, 0, 0, '0});
		rows.push_back('{-18'sd65536, 0, 0, '0});
		rows.push_back('{18'sd65535, 0, 0, '0});
		rows.push_back('{18'sd0, 0, 0, '0});
		rows.push_back('{18'sd1, 0, 0, '0});
		rows.push_back('{-18'sd1, 0, 0, '0});
		rows.push_back('{18'sd32768, 0, 0, '0});
		rows.push_back('{18'sd12345, 1, 0, '0});
		for (int i = 0; i < 7; i++) rows.push_back('{18'sd40000 - 18'(i * 5000), 0, 0, '0});
		rows.push_back('{-18'sd7, 1, 1, err_res});

		foreach (rows[i]) begin
			send_sample(rows[i].sample, rows[i].last, rows[i].typed, rows[i].want);
			if (rows[i].last) drain();
		end

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin bv = 0; qv = 0; end
				1: begin bv = 1024; qv = 127; end
				2: begin bv = 2047; qv = 3; end
				3: begin bv = 1; qv = 1; end
				4: begin bv = 3; qv = 2; end
				default: begin
					bv = 16'($urandom_range(1, 1024));
					if ($urandom_range(0, 1)) bv = 16'($urandom_range(1, 40));
					qv = 16'($urandom_range(1, 12));
				end
			endcase
			if (ph >= 5 && $urandom_range(0, 4) == 0) bv = 16'($urandom);
			cfg_write(8'(REG_BIN_COUNT), bv);
			cfg_write(8'(REG_QUANT_COUNT), qv);
			q = int'((quants_reg == 0) ? 1 :
				(quants_reg > MAX_QUANTS ? MAX_QUANTS : quants_reg));
			if ($urandom_range(0, 5) == 0) n = $urandom_range(1, q);
			else n = q + $urandom_range(1, 8);
			if (n > 70) n = 70;
			for (int j = 0; j < n; j++) send_sample(rand_sample(), j == n - 1);
			drain();
		end

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
